[hw/rtl/hps_pkg.sv]
// Shared constants and types for the haptic pattern sequencer.
package hps_pkg;

  localparam int PATTERN_COUNT_DEF     = 16;
  localparam int STEPS_PER_PATTERN_DEF = 16;

  localparam int MODE_W      = 3;
  localparam int PATTERN_W   = 4;
  localparam int SLOT_W      = 4;
  localparam int INTENSITY_W = 8;
  localparam int DURATION_W  = 16;
  localparam int ENTRY_W     = INTENSITY_W + DURATION_W;
  localparam int TIMER_W     = 26;
  localparam int STALE_W     = 8;

  localparam logic [9:0]         US_PER_MS = 10'd1000;
  localparam logic [STALE_W-1:0] STALE_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAY_ONCE   = 3'd0,
    MODE_PLAY_REPEAT = 3'd1,
    MODE_STOP        = 3'd2,
    MODE_EXPIRE      = 3'd3,
    MODE_LOAD        = 3'd4
  } mode_t;

endpackage

[hw/rtl/haptic_pattern_sequencer_unit.sv]
// Haptic pattern sequencer: step table memory, playback state and event resolution.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_stall  | mode pattern play_allowed cancel_caught_timer
//           |                      | timer_start_ok step_slot step_intensity
//           |                      | step_duration_ms
//  out      | out_valid / out_stall| accepted motor_write motor_level timer_start
//           |                      | timer_duration_us timer_cancel playing_pattern repeating
//
// The transfer cycle issues both table reads (step 0 of the pattern and, for an expiry, the
// next step); the event is then resolved and the playback state updated. The next event's
// read address depends on that resolved position, so one event is in flight. Reset (rst,
// synchronous) clears playback state and both channels; the step table keeps its contents
// and is undefined until loaded. A stalled output holds its result while the next event's
// table reads go ahead; the resolving event waits for the output register to free.
module haptic_pattern_sequencer_unit #(
  parameter int PATTERN_COUNT     = hps_pkg::PATTERN_COUNT_DEF,
  parameter int STEPS_PER_PATTERN = hps_pkg::STEPS_PER_PATTERN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hps_pkg::MODE_W-1:0]        mode,
  input  logic [hps_pkg::PATTERN_W-1:0]     pattern,
  input  logic                              play_allowed,
  input  logic                              cancel_caught_timer,
  input  logic                              timer_start_ok,
  input  logic [hps_pkg::SLOT_W-1:0]        step_slot,
  input  logic [hps_pkg::INTENSITY_W-1:0]   step_intensity,
  input  logic [hps_pkg::DURATION_W-1:0]    step_duration_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic                              motor_write,
  output logic [hps_pkg::INTENSITY_W-1:0]   motor_level,
  output logic                              timer_start,
  output logic [hps_pkg::TIMER_W-1:0]       timer_duration_us,
  output logic                              timer_cancel,
  output logic [hps_pkg::PATTERN_W-1:0]     playing_pattern,
  output logic                              repeating
);

  localparam int DEPTH = PATTERN_COUNT * STEPS_PER_PATTERN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (STEPS_PER_PATTERN > 1) ? $clog2(STEPS_PER_PATTERN) : 1;
  localparam int PW    = SW + 1;

  logic [hps_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [hps_pkg::ENTRY_W-1:0] rd0;
  logic [hps_pkg::ENTRY_W-1:0] rd1;

  logic [hps_pkg::PATTERN_W-1:0] cur_pat;
  logic [SW-1:0]                 pos;
  logic                          rep;
  logic [hps_pkg::STALE_W-1:0]   stale;

  logic                          s1_valid;
  hps_pkg::mode_t                q_mode;
  logic [hps_pkg::PATTERN_W-1:0] q_pat;
  logic                          q_avail;
  logic                          q_caught;
  logic                          q_start_ok;
  logic                          q_pos_ok;
  logic                          q_load_ok;

  logic          in_xfer;
  logic          out_free;
  logic          finish;
  logic          pat_ok;
  logic          slot_ok;
  logic          load_we;
  logic [PW-1:0] pos_inc;
  logic          pos_inc_ok;
  logic          is_expire;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;

  logic [hps_pkg::PATTERN_W-1:0]   cur_pat_next;
  logic [SW-1:0]                   pos_next;
  logic                            rep_next;
  logic [hps_pkg::STALE_W-1:0]     stale_next;
  logic                            acc_next;
  logic                            mw_next;
  logic [hps_pkg::INTENSITY_W-1:0] lvl_next;
  logic                            ts_next;
  logic [hps_pkg::TIMER_W-1:0]     tus_next;
  logic                            tc_next;

  assign out_free = !out_valid || !out_stall;
  assign finish   = s1_valid && out_free;
  assign in_stall = s1_valid;
  assign in_xfer  = in_valid && !s1_valid;

  assign pat_ok     = 32'(pattern) < PATTERN_COUNT;
  assign slot_ok    = 32'(step_slot) < STEPS_PER_PATTERN;
  assign load_we    = in_xfer && (hps_pkg::mode_t'(mode) == hps_pkg::MODE_LOAD) && pat_ok
                      && slot_ok;
  assign is_expire  = hps_pkg::mode_t'(mode) == hps_pkg::MODE_EXPIRE;
  assign pos_inc    = PW'(pos) + PW'(1);
  assign pos_inc_ok = 32'(pos_inc) < STEPS_PER_PATTERN;

  always_comb begin
    wr_addr  = AW'(32'(pattern) * STEPS_PER_PATTERN + 32'(step_slot));
    rd_addr1 = AW'(32'(is_expire ? cur_pat : pattern) * STEPS_PER_PATTERN);
    if (is_expire && pos_inc_ok) begin
      rd_addr0 = AW'(32'(cur_pat) * STEPS_PER_PATTERN + 32'(pos_inc));
    end else begin
      rd_addr0 = rd_addr1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[wr_addr] <= {step_intensity, step_duration_ms};
    end
    if (in_xfer) begin
      rd0 <= mem[rd_addr0];
      rd1 <= mem[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_mode     <= hps_pkg::mode_t'(mode);
      q_pat      <= pattern;
      q_avail    <= play_allowed;
      q_caught   <= cancel_caught_timer;
      q_start_ok <= timer_start_ok;
      q_pos_ok   <= !is_expire || pos_inc_ok;
      q_load_ok  <= pat_ok && slot_ok;
    end
  end

  always_comb begin
    logic                            do_cancel;
    logic                            do_fail;
    logic                            do_arm;
    logic                            q_pat_ok;
    logic [hps_pkg::DURATION_W-1:0]  d;
    logic [hps_pkg::INTENSITY_W-1:0] l;

    cur_pat_next = cur_pat;
    pos_next     = pos;
    rep_next     = rep;
    stale_next   = stale;
    acc_next     = 1'b0;
    mw_next      = 1'b0;
    lvl_next     = '0;
    ts_next      = 1'b0;
    tus_next     = '0;
    tc_next      = 1'b0;
    do_cancel    = 1'b0;
    do_fail      = 1'b0;
    do_arm       = 1'b0;
    q_pat_ok     = 32'(q_pat) < PATTERN_COUNT;
    d            = '0;
    l            = '0;

    case (q_mode)
      hps_pkg::MODE_PLAY_ONCE: begin
        if (q_pat_ok && !rep) begin
          do_cancel = 1'b1;
          if (q_pat == '0) begin
            do_fail  = 1'b1;
            acc_next = 1'b1;
          end else begin
            cur_pat_next = q_pat;
            pos_next     = '0;
            do_arm       = 1'b1;
          end
        end
      end
      hps_pkg::MODE_PLAY_REPEAT: begin
        if (q_avail && q_pat != '0 && q_pat_ok) begin
          rep_next     = 1'b1;
          do_cancel    = 1'b1;
          cur_pat_next = q_pat;
          pos_next     = '0;
          do_arm       = 1'b1;
        end
      end
      hps_pkg::MODE_STOP: begin
        do_cancel = 1'b1;
        do_fail   = 1'b1;
        acc_next  = 1'b1;
      end
      hps_pkg::MODE_EXPIRE: begin
        if (stale != '0) begin
          stale_next = stale - 1'b1;
          acc_next   = 1'b1;
        end else if (cur_pat == '0) begin
          acc_next = 1'b1;
        end else begin
          pos_next = SW'(pos_inc);
          do_arm   = 1'b1;
        end
      end
      hps_pkg::MODE_LOAD: begin
        acc_next = q_load_ok;
      end
      default: begin
        acc_next = 1'b0;
      end
    endcase

    // cancel sees the pattern that was playing before this event
    if (do_cancel) begin
      tc_next = 1'b1;
      if (cur_pat != '0 && !q_caught && stale != hps_pkg::STALE_MAX) begin
        stale_next = stale + 1'b1;
      end
    end

    if (do_arm) begin
      if (q_pos_ok) begin
        d = rd0[hps_pkg::DURATION_W-1:0];
        l = rd0[hps_pkg::ENTRY_W-1:hps_pkg::DURATION_W];
      end
      if (d == '0) begin
        if (!rep_next) begin
          do_fail  = 1'b1;
          acc_next = 1'b1;
        end else begin
          pos_next = '0;
          d        = rd1[hps_pkg::DURATION_W-1:0];
          l        = rd1[hps_pkg::ENTRY_W-1:hps_pkg::DURATION_W];
          if (d == '0) begin
            do_fail  = 1'b1;
            acc_next = 1'b0;
          end
        end
      end
      if (d != '0) begin
        mw_next  = 1'b1;
        lvl_next = l;
        ts_next  = 1'b1;
        tus_next = hps_pkg::TIMER_W'(d) * hps_pkg::TIMER_W'(hps_pkg::US_PER_MS);
        acc_next = q_start_ok;
        do_fail  = !q_start_ok;
      end
    end

    if (do_fail) begin
      rep_next     = 1'b0;
      cur_pat_next = '0;
      pos_next     = '0;
      mw_next      = 1'b1;
      lvl_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cur_pat   <= '0;
      pos       <= '0;
      rep       <= 1'b0;
      stale     <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (finish) begin
        s1_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
        cur_pat   <= cur_pat_next;
        pos       <= pos_next;
        rep       <= rep_next;
        stale     <= stale_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      accepted          <= acc_next;
      motor_write       <= mw_next;
      motor_level       <= lvl_next;
      timer_start       <= ts_next;
      timer_duration_us <= tus_next;
      timer_cancel      <= tc_next;
      playing_pattern   <= cur_pat_next;
      repeating         <= rep_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < STEPS_PER_PATTERN)
    else $error("step position past last slot");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (cur_pat == '0) |-> (!rep && pos == '0))
    else $error("idle with repeat or position set");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("resolved event lost before output register");

  a_no_timer_dur: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !timer_start) |-> (timer_duration_us == '0))
    else $error("timer duration without timer start");
`endif

endmodule

[verif/tb.sv]
// Testbench for haptic_pattern_sequencer_unit: event stream with random gaps, predicted results.
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_CYCLES     = 10;
  localparam int RANDOM_EVENTS  = 260;
  localparam int STORM_PLAYS    = 257;
  localparam int STORM_EXPIRES  = 4;
  localparam logic [hps_pkg::MODE_W-1:0] MODE_UNUSED_LO = hps_pkg::MODE_LOAD + 3'd1;
  localparam logic [hps_pkg::MODE_W-1:0] MODE_UNUSED_HI = '1;

  typedef struct packed {
    logic [hps_pkg::MODE_W-1:0]      mode;
    logic [hps_pkg::PATTERN_W-1:0]   pattern;
    logic                            avail;
    logic                            caught;
    logic                            start_ok;
    logic [hps_pkg::SLOT_W-1:0]      slot;
    logic [hps_pkg::INTENSITY_W-1:0] intensity;
    logic [hps_pkg::DURATION_W-1:0]  duration;
  } haptic_event_t;

  typedef struct packed {
    logic                            accepted;
    logic                            motor_write;
    logic [hps_pkg::INTENSITY_W-1:0] motor_level;
    logic                            timer_start;
    logic [hps_pkg::TIMER_W-1:0]     timer_us;
    logic                            timer_cancel;
    logic [hps_pkg::PATTERN_W-1:0]   playing;
    logic                            repeating;
  } event_result_t;

  typedef struct packed {
    haptic_event_t ev;
    event_result_t res;
  } queued_event_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [hps_pkg::MODE_W-1:0]      mode = '0;
  logic [hps_pkg::PATTERN_W-1:0]   pattern = '0;
  logic                            play_allowed = 1'b0;
  logic                            cancel_caught_timer = 1'b0;
  logic                            timer_start_ok = 1'b0;
  logic [hps_pkg::SLOT_W-1:0]      step_slot = '0;
  logic [hps_pkg::INTENSITY_W-1:0] step_intensity = '0;
  logic [hps_pkg::DURATION_W-1:0]  step_duration_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            accepted;
  logic                            motor_write;
  logic [hps_pkg::INTENSITY_W-1:0] motor_level;
  logic                            timer_start;
  logic [hps_pkg::TIMER_W-1:0]     timer_duration_us;
  logic                            timer_cancel;
  logic [hps_pkg::PATTERN_W-1:0]   playing_pattern;
  logic                            repeating;

  haptic_pattern_sequencer_unit DUT (.*);

  // predicted sequencer state
  logic [hps_pkg::INTENSITY_W-1:0] level_tbl [hps_pkg::PATTERN_COUNT_DEF]
                                             [hps_pkg::STEPS_PER_PATTERN_DEF];
  logic [hps_pkg::DURATION_W-1:0]  dur_tbl   [hps_pkg::PATTERN_COUNT_DEF]
                                             [hps_pkg::STEPS_PER_PATTERN_DEF];
  bit                              loaded    [hps_pkg::PATTERN_COUNT_DEF]
                                             [hps_pkg::STEPS_PER_PATTERN_DEF];
  logic [hps_pkg::PATTERN_W-1:0]   play_pat = '0;
  logic [hps_pkg::SLOT_W:0]        play_pos = '0;
  bit                              rep_on = 1'b0;
  logic [hps_pkg::STALE_W-1:0]     stale_cnt = '0;
  event_result_t                   pred_res;
  logic [hps_pkg::PATTERN_W-1:0]   blank_pat;
  logic [hps_pkg::SLOT_W-1:0]      blank_slot;

  queued_event_t event_q[$];
  event_result_t result_q[$];
  event_result_t in_flight_res;
  bit            in_taken = 1'b0;
  int            send_gap = 0;
  bit            send_quiet = 1'b0;
  int            hold_left = 0;
  bit            hold_quiet = 1'b0;
  int            idle_cycles = 0;
  int            fail_count = 0;

  function automatic void drop_timer(bit caught);
    pred_res.timer_cancel = 1'b1;
    if (play_pat != 0 && !caught && stale_cnt != hps_pkg::STALE_MAX) stale_cnt++;
  endfunction

  function automatic void shut_motor();
    rep_on = 1'b0;
    play_pat = '0;
    play_pos = '0;
    pred_res.motor_write = 1'b1;
    pred_res.motor_level = '0;
  endfunction

  function automatic bit arm_step(bit start_ok);
    logic [hps_pkg::DURATION_W-1:0]  d;
    logic [hps_pkg::INTENSITY_W-1:0] l;
    d = '0;
    l = '0;
    if (play_pos < hps_pkg::STEPS_PER_PATTERN_DEF) begin
      d = dur_tbl[play_pat][play_pos[hps_pkg::SLOT_W-1:0]];
      l = level_tbl[play_pat][play_pos[hps_pkg::SLOT_W-1:0]];
    end
    if (d == 0) begin
      if (!rep_on) begin
        shut_motor();
        return 1'b1;
      end
      play_pos = '0;
      d = dur_tbl[play_pat][0];
      l = level_tbl[play_pat][0];
      if (d == 0) begin
        shut_motor();
        return 1'b0;
      end
    end
    pred_res.motor_write = 1'b1;
    pred_res.motor_level = l;
    pred_res.timer_start = 1'b1;
    pred_res.timer_us = hps_pkg::TIMER_W'(d) * hps_pkg::TIMER_W'(hps_pkg::US_PER_MS);
    if (!start_ok) begin
      shut_motor();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic event_result_t resolve_event(haptic_event_t ev);
    bit ok;
    ok = 1'b0;
    pred_res = '0;
    case (ev.mode)
      hps_pkg::MODE_PLAY_ONCE: begin
        if (!rep_on) begin
          drop_timer(ev.caught);
          if (ev.pattern == 0) begin
            shut_motor();
            ok = 1'b1;
          end else begin
            play_pat = ev.pattern;
            play_pos = '0;
            ok = arm_step(ev.start_ok);
          end
        end
      end
      hps_pkg::MODE_PLAY_REPEAT: begin
        if (ev.avail && ev.pattern != 0) begin
          rep_on = 1'b1;
          drop_timer(ev.caught);
          play_pat = ev.pattern;
          play_pos = '0;
          ok = arm_step(ev.start_ok);
        end
      end
      hps_pkg::MODE_STOP: begin
        drop_timer(ev.caught);
        shut_motor();
        ok = 1'b1;
      end
      hps_pkg::MODE_EXPIRE: begin
        if (stale_cnt != 0) begin
          stale_cnt--;
          ok = 1'b1;
        end else if (play_pat == 0) begin
          ok = 1'b1;
        end else begin
          play_pos++;
          ok = arm_step(ev.start_ok);
        end
      end
      hps_pkg::MODE_LOAD: begin
        level_tbl[ev.pattern][ev.slot] = ev.intensity;
        dur_tbl[ev.pattern][ev.slot] = ev.duration;
        loaded[ev.pattern][ev.slot] = 1'b1;
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    pred_res.accepted = ok;
    pred_res.playing = play_pat;
    pred_res.repeating = rep_on;
    return pred_res;
  endfunction

  // find a table entry the event would read before it was ever loaded
  function automatic bit reads_blank(haptic_event_t ev);
    logic [hps_pkg::SLOT_W:0] nxt;
    nxt = play_pos + 1'b1;
    case (ev.mode)
      hps_pkg::MODE_PLAY_ONCE, hps_pkg::MODE_PLAY_REPEAT: begin
        if ((ev.mode == hps_pkg::MODE_PLAY_REPEAT ? ev.avail : !rep_on) &&
            ev.pattern != 0 && !loaded[ev.pattern][0]) begin
          blank_pat = ev.pattern;
          blank_slot = '0;
          return 1'b1;
        end
      end
      hps_pkg::MODE_EXPIRE: begin
        if (stale_cnt == 0 && play_pat != 0) begin
          blank_pat = play_pat;
          if (nxt < hps_pkg::STEPS_PER_PATTERN_DEF &&
              !loaded[play_pat][nxt[hps_pkg::SLOT_W-1:0]]) begin
            blank_slot = nxt[hps_pkg::SLOT_W-1:0];
            return 1'b1;
          end
          if (rep_on && !loaded[play_pat][0]) begin
            blank_slot = '0;
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic haptic_event_t make_event(logic [hps_pkg::MODE_W-1:0] m,
                                               logic [hps_pkg::PATTERN_W-1:0] p,
                                               bit av, bit ca, bit ok,
                                               logic [hps_pkg::SLOT_W-1:0] sl,
                                               logic [hps_pkg::INTENSITY_W-1:0] it,
                                               logic [hps_pkg::DURATION_W-1:0] du);
    haptic_event_t ev;
    ev.mode = m;
    ev.pattern = p;
    ev.avail = av;
    ev.caught = ca;
    ev.start_ok = ok;
    ev.slot = sl;
    ev.intensity = it;
    ev.duration = du;
    return ev;
  endfunction

  function automatic haptic_event_t random_event();
    haptic_event_t ev;
    int unsigned   pick;
    int unsigned   dpick;
    pick = $urandom_range(0, 99);
    dpick = $urandom_range(0, 9);
    ev = make_event(hps_pkg::MODE_EXPIRE, hps_pkg::PATTERN_W'($urandom),
                    $urandom_range(0, 7) != 0,
                    $urandom_range(0, 3) != 0, $urandom_range(0, 15) != 0,
                    $urandom_range(0, 3) == 0 ? hps_pkg::SLOT_W'($urandom) :
                                                hps_pkg::SLOT_W'($urandom_range(0, 3)),
                    hps_pkg::INTENSITY_W'($urandom),
                    dpick == 0 ? '0 : dpick == 1 ? '1 :
                                 hps_pkg::DURATION_W'($urandom_range(1, 65535)));
    if (pick < 25) ev.mode = hps_pkg::MODE_LOAD;
    else if (pick < 45) ev.mode = hps_pkg::MODE_PLAY_ONCE;
    else if (pick < 58) ev.mode = hps_pkg::MODE_PLAY_REPEAT;
    else if (pick < 66) ev.mode = hps_pkg::MODE_STOP;
    else if (pick >= 97)
      ev.mode = hps_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    return ev;
  endfunction

  function automatic void queue_event(haptic_event_t ev);
    queued_event_t qe;
    if (reads_blank(ev)) begin
      ev.mode = hps_pkg::MODE_LOAD;
      ev.pattern = blank_pat;
      ev.slot = blank_slot;
    end
    qe.ev = ev;
    qe.res = resolve_event(ev);
    event_q.push_back(qe);
  endfunction

  task automatic wait_for_idle();
    while (event_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      result_q.push_back(in_flight_res);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    queued_event_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (event_q.size() != 0) begin
        cur = event_q.pop_front();
        in_flight_res = cur.res;
        mode <= cur.ev.mode;
        pattern <= cur.ev.pattern;
        play_allowed <= cur.ev.avail;
        cancel_caught_timer <= cur.ev.caught;
        timer_start_ok <= cur.ev.start_ok;
        step_slot <= cur.ev.slot;
        step_intensity <= cur.ev.intensity;
        step_duration_ms <= cur.ev.duration;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    event_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result transfer with no event outstanding");
        fail_count++;
      end else begin
        want = result_q.pop_front();
        check_field("accepted", want.accepted, accepted);
        check_field("motor_write", want.motor_write, motor_write);
        check_field("motor_level", want.motor_level, motor_level);
        check_field("timer_start", want.timer_start, timer_start);
        check_field("timer_duration_us", want.timer_us, timer_duration_us);
        check_field("timer_cancel", want.timer_cancel, timer_cancel);
        check_field("playing_pattern", want.playing, playing_pattern);
        check_field("repeating", want.repeating, repeating);
      end
      if ($urandom_range(0, 39) == 0) hold_quiet = !hold_quiet;
      hold_left = hold_quiet ? 0 : $urandom_range(0, 19);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd1, 1'b0, 1'b0, 1'b0, 4'd0, 8'hff, 16'hffff));
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd1, 1'b1, 1'b1, 1'b1, 4'd1, 8'h00, 16'd1));
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd1, 1'b0, 1'b1, 1'b0, 4'd2, 8'h80, 16'd0));
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd15, 1'b1, 1'b0, 1'b1, 4'd0, 8'h01, 16'd500));
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd15, 1'b0, 1'b0, 1'b0, 4'd15, 8'haa,
                           16'h5555));
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd3, 1'b1, 1'b1, 1'b1, 4'd0, 8'h07, 16'd0));
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
      queue_event(make_event(hps_pkg::MODE_W'(m), hps_pkg::PATTERN_W'($urandom),
                             1'b1, 1'b1, 1'b1, hps_pkg::SLOT_W'($urandom),
                             hps_pkg::INTENSITY_W'($urandom),
                             hps_pkg::DURATION_W'($urandom)));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd1, 1'b1, 1'b0, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_REPEAT, 4'd1, 1'b0, 1'b1, 1'b1, 4'd0, 8'd0,
                           16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_REPEAT, 4'd1, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0,
                           16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd1, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_STOP, 4'd0, 1'b1, 1'b0, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_REPEAT, 4'd3, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0,
                           16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd15, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0,
                           16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd1, 1'b1, 1'b0, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_ONCE, 4'd15, 1'b1, 1'b1, 1'b0, 4'd0, 8'd0,
                           16'd0));
    queue_event(make_event(hps_pkg::MODE_EXPIRE, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0, 16'd0));
    queue_event(make_event(hps_pkg::MODE_PLAY_REPEAT, 4'd0, 1'b1, 1'b1, 1'b1, 4'd0, 8'd0,
                           16'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hold new events until the directed ones have all come back
    wait_for_idle();
    repeat (RANDOM_EVENTS) queue_event(random_event());

    // drive the stale-expiry counter into saturation, then swallow a few expiries
    queue_event(make_event(hps_pkg::MODE_LOAD, 4'd1, 1'b1, 1'b1, 1'b1, 4'd0,
                           hps_pkg::INTENSITY_W'($urandom),
                           hps_pkg::DURATION_W'($urandom_range(1, 65535))));
    repeat (STORM_PLAYS)
      queue_event(make_event(hps_pkg::MODE_PLAY_REPEAT, 4'd1, 1'b1, 1'b0, 1'b1,
                             hps_pkg::SLOT_W'($urandom), hps_pkg::INTENSITY_W'($urandom),
                             hps_pkg::DURATION_W'($urandom)));
    repeat (STORM_EXPIRES)
      queue_event(make_event(hps_pkg::MODE_EXPIRE, hps_pkg::PATTERN_W'($urandom),
                             $urandom_range(0, 1) != 0,
                             $urandom_range(0, 1) != 0, $urandom_range(0, 7) != 0,
                             hps_pkg::SLOT_W'($urandom), hps_pkg::INTENSITY_W'($urandom),
                             $urandom_range(0, 3) == 0 ? '0 :
                                                         hps_pkg::DURATION_W'($urandom)));

    wait_for_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
